>>> rtl/ogns_pkg.sv
`timescale 1ns / 1ps

package ogns_pkg;

    // Default board limit in each direction.
    localparam int MAX_DIM_DEF = 64;

    // Fixed field widths.
    localparam int COORD_W = 9;
    localparam int POS_W   = 6;
    localparam int CFG_W   = 7;
    localparam int CNT_W   = 13;
    localparam int SCORE_W = 4;

    // Board dimension registers come out of reset at this value.
    localparam logic [CFG_W-1:0] DIM_RST = 7'd64;

    // Request kinds.
    typedef enum logic {
        REQ_PLACE,
        REQ_READ
    } req_kind_t;

    // Configuration register indexes.
    typedef enum logic {
        CFG_BOARD_WIDTH,
        CFG_BOARD_HEIGHT
    } cfg_idx_t;

    // Request payload.
    typedef struct packed {
        logic                      req_type;
        logic signed [COORD_W-1:0] rect_left;
        logic signed [COORD_W-1:0] rect_right;
        logic signed [COORD_W-1:0] rect_top;
        logic signed [COORD_W-1:0] rect_bottom;
        logic [POS_W-1:0]          col_x;
        logic [POS_W-1:0]          row_y;
    } req_t;

    // Result payload.
    typedef struct packed {
        logic               cell_used;
        logic [SCORE_W-1:0] cell_score;
        logic [CNT_W-1:0]   free_cells;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_wr;
        logic capture;
        logic row_rd;
        logic row_load;
        logic walk;
        logic row_wr;
        logic nb_acc;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic is_read;
        logic rect_empty;
        logic cell_last;
        logic row_last;
        logic nb_last;
        logic out_free;
    } stat_t;

endpackage

>>> rtl/ogns_if.sv
`timescale 1ns / 1ps

// Request channel.
interface ogns_req_if;
    logic                               valid;
    logic                               ready;
    logic                               req_type;
    logic signed [ogns_pkg::COORD_W-1:0] rect_left;
    logic signed [ogns_pkg::COORD_W-1:0] rect_right;
    logic signed [ogns_pkg::COORD_W-1:0] rect_top;
    logic signed [ogns_pkg::COORD_W-1:0] rect_bottom;
    logic [ogns_pkg::POS_W-1:0]          col_x;
    logic [ogns_pkg::POS_W-1:0]          row_y;

    modport source (
        output valid, req_type, rect_left, rect_right, rect_top, rect_bottom, col_x, row_y,
        input  ready
    );
    modport sink (
        input  valid, req_type, rect_left, rect_right, rect_top, rect_bottom, col_x, row_y,
        output ready
    );
endinterface

// Result channel.
interface ogns_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          cell_used;
    logic [ogns_pkg::SCORE_W-1:0]  cell_score;
    logic [ogns_pkg::CNT_W-1:0]    free_cells;

    modport source (
        output valid, cell_used, cell_score, free_cells,
        input  ready
    );
    modport sink (
        input  valid, cell_used, cell_score, free_cells,
        output ready
    );
endinterface

>>> rtl/occupancy_grid_neighbor_score_core.sv
`timescale 1ns / 1ps

// Occupancy grid with neighbor scoring. The board is kept one row per memory
// word, and the row memory, with one write port and a registered read port,
// sets the pace: after reset a clearing pass writes MAX_DIM rows before the
// first request is taken. A read request visits three neighbor rows, reading
// each one and then accumulating it. A place request walks its clipped
// rectangle cell by cell, reading and writing back each row; a rectangle that
// clips to nothing skips the walk. One request is worked on at a time; the
// next may be taken while the previous result waits in the output register.
module occupancy_grid_neighbor_score_core #(
    parameter int MAX_DIM = ogns_pkg::MAX_DIM_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    ogns_req_if.sink                    req,
    ogns_rsp_if.source                  rsp,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [ogns_pkg::CFG_W-1:0]  cfg_data
);
    import ogns_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    req_t  req_pl;
    rsp_t  rsp_pl;
    logic  ready_w;

    // Gather request fields.
    assign req_pl.req_type    = req.req_type;
    assign req_pl.rect_left   = req.rect_left;
    assign req_pl.rect_right  = req.rect_right;
    assign req_pl.rect_top    = req.rect_top;
    assign req_pl.rect_bottom = req.rect_bottom;
    assign req_pl.col_x       = req.col_x;
    assign req_pl.row_y       = req.row_y;
    assign req.ready          = ready_w;

    ogns_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (ready_w),
        .stat      (stat),
        .cmd       (cmd)
    );

    ogns_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .req_pl    (req_pl),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp.valid),
        .rsp_pl    (rsp_pl)
    );

    // Spread result fields.
    assign rsp.cell_used  = rsp_pl.cell_used;
    assign rsp.cell_score = rsp_pl.cell_score;
    assign rsp.free_cells = rsp_pl.free_cells;

endmodule

>>> rtl/ogns_row_mem.sv
`timescale 1ns / 1ps

module ogns_row_mem #(
    parameter int MAX_DIM = ogns_pkg::MAX_DIM_DEF
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(MAX_DIM > 1 ? $clog2(MAX_DIM) : 1)-1:0] waddr,
    input  logic [MAX_DIM-1:0]                    wdata,
    input  logic [(MAX_DIM > 1 ? $clog2(MAX_DIM) : 1)-1:0] raddr,
    output logic [MAX_DIM-1:0]                    rdata
);
    import ogns_pkg::*;

    // One word per board row, one bit per column.
    logic [MAX_DIM-1:0] mem [MAX_DIM];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/ogns_dp.sv
`timescale 1ns / 1ps

module ogns_dp #(
    parameter int MAX_DIM = ogns_pkg::MAX_DIM_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ogns_pkg::cmd_t               cmd,
    output ogns_pkg::stat_t              stat,
    input  ogns_pkg::req_t               req_pl,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [ogns_pkg::CFG_W-1:0]   cfg_data,
    input  logic                         rsp_ready,
    output logic                         rsp_valid,
    output ogns_pkg::rsp_t               rsp_pl
);
    import ogns_pkg::*;

    localparam int IDX_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W    = $clog2(MAX_DIM + 1);
    localparam int SW       = ((DIM_W > COORD_W) ? DIM_W : COORD_W) + 1;
    localparam int RST_DIM  = (MAX_DIM < int'(DIM_RST)) ? MAX_DIM : int'(DIM_RST);
    localparam int RST_FREE = RST_DIM * RST_DIM;

    // Dimension register value as used: zero acts as one, large values saturate.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (32'(v) > MAX_DIM)
        begin
            r = DIM_W'(MAX_DIM);
        end
        else
        begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

    // Clamp a signed coordinate to the range zero to lim.
    function automatic logic [DIM_W-1:0] clip(input logic signed [COORD_W-1:0] v,
                                              input logic [DIM_W-1:0] lim);
        logic signed [SW-1:0] vs;
        logic [DIM_W-1:0]     r;
        vs = SW'(v);
        if (vs[SW-1])
        begin
            r = '0;
        end
        else if (vs > $signed(SW'(lim)))
        begin
            r = lim;
        end
        else
        begin
            r = DIM_W'(vs);
        end
        return r;
    endfunction

    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic [DIM_W-1:0]   w_eff;
    logic [DIM_W-1:0]   h_eff;

    logic               kind_reg;
    logic [DIM_W-1:0]   x0_reg;
    logic [DIM_W-1:0]   x1_reg;
    logic [DIM_W-1:0]   y0_reg;
    logic [DIM_W-1:0]   y1_reg;
    logic [POS_W-1:0]   cx_reg;
    logic [POS_W-1:0]   cy_reg;
    logic [DIM_W-1:0]   y0_clip;

    logic [IDX_W-1:0]   cur_x_reg;
    logic [IDX_W-1:0]   cur_y_reg;
    logic [IDX_W-1:0]   clr_reg;
    logic [MAX_DIM-1:0] row_reg;
    logic [CNT_W-1:0]   free_reg;
    logic [1:0]         dy_reg;
    logic [SCORE_W-1:0] acc_reg;
    logic               used_reg;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [MAX_DIM-1:0] mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;
    logic [MAX_DIM-1:0] mem_rdata;

    logic [SW-1:0]      nb_y;
    logic               row_out;
    logic [2:0]         occ;
    logic [SCORE_W-1:0] occ_sum;
    logic               new_cell;

    assign w_eff   = eff_dim(width_reg);
    assign h_eff   = eff_dim(height_reg);
    assign y0_clip = clip(req_pl.rect_top, h_eff);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_RST;
            height_reg <= DIM_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_BOARD_WIDTH:  width_reg  <= cfg_data;
                CFG_BOARD_HEIGHT: height_reg <= cfg_data;
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    // Neighbor row under inspection and the three cells of it that matter.
    assign nb_y    = SW'(cy_reg) + SW'(dy_reg) - SW'(1);
    assign row_out = nb_y[SW-1] || (nb_y >= SW'(h_eff));

    always_comb
    begin
        logic [SW-1:0] nb_x;
        for (int i = 0; i < 3; i++)
        begin
            nb_x = SW'(cx_reg) + SW'(i) - SW'(1);
            if (row_out || nb_x[SW-1] || (nb_x >= SW'(w_eff)))
            begin
                occ[i] = 1'b1;
            end
            else
            begin
                occ[i] = mem_rdata[IDX_W'(nb_x)];
            end
        end
    end

    assign occ_sum  = SCORE_W'(occ[0]) + SCORE_W'(occ[1]) + SCORE_W'(occ[2]);
    assign new_cell = !row_reg[cur_x_reg];

    // Memory port selection.
    assign mem_we    = cmd.clr_wr || cmd.row_wr;
    assign mem_waddr = cmd.clr_wr ? clr_reg : cur_y_reg;
    assign mem_wdata = cmd.clr_wr ? '0 : row_reg;
    assign mem_raddr = cmd.row_rd ? cur_y_reg : IDX_W'(nb_y);

    ogns_row_mem #(
        .MAX_DIM (MAX_DIM)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Request fields captured at acceptance, rectangle already clipped.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= req_pl.req_type;
            x0_reg   <= clip(req_pl.rect_left, w_eff);
            x1_reg   <= clip(req_pl.rect_right, w_eff);
            y0_reg   <= y0_clip;
            y1_reg   <= clip(req_pl.rect_bottom, h_eff);
            cx_reg   <= req_pl.col_x;
            cy_reg   <= req_pl.row_y;
        end
    end

    // Cursor and row buffer for the rectangle walk.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cur_y_reg <= IDX_W'(y0_clip);
        end
        else if (cmd.row_wr)
        begin
            cur_y_reg <= cur_y_reg + IDX_W'(1);
        end

        if (cmd.row_rd)
        begin
            cur_x_reg <= IDX_W'(x0_reg);
        end
        else if (cmd.walk)
        begin
            cur_x_reg <= cur_x_reg + IDX_W'(1);
        end

        if (cmd.row_load)
        begin
            row_reg <= mem_rdata;
        end
        else if (cmd.walk)
        begin
            row_reg <= row_reg | (MAX_DIM'(1) << cur_x_reg);
        end
    end

    // Free-cell count, neighbor accumulation and clearing sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg <= CNT_W'(RST_FREE);
            clr_reg  <= '0;
            dy_reg   <= '0;
            acc_reg  <= '0;
            used_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_wr)
            begin
                clr_reg <= clr_reg + IDX_W'(1);
            end

            if (cmd.walk && new_cell && (free_reg != '0))
            begin
                free_reg <= free_reg - CNT_W'(1);
            end

            if (cmd.capture)
            begin
                dy_reg   <= '0;
                acc_reg  <= '0;
                used_reg <= 1'b0;
            end
            else if (cmd.nb_acc)
            begin
                dy_reg  <= dy_reg + 2'd1;
                acc_reg <= acc_reg + occ_sum;
                if (dy_reg == 2'd1)
                begin
                    used_reg <= occ[1];
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rsp_reg.cell_used  <= used_reg;
            rsp_reg.cell_score <= used_reg ? '0 : acc_reg;
            rsp_reg.free_cells <= free_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_pl    = rsp_reg;

    // Status toward the controller.
    assign stat.clr_last   = (clr_reg == IDX_W'(MAX_DIM - 1));
    assign stat.is_read    = (req_kind_t'(kind_reg) == REQ_READ);
    assign stat.rect_empty = (x1_reg <= x0_reg) || (y1_reg <= y0_reg);
    assign stat.cell_last  = ((DIM_W'(cur_x_reg) + DIM_W'(1)) == x1_reg);
    assign stat.row_last   = ((DIM_W'(cur_y_reg) + DIM_W'(1)) == y1_reg);
    assign stat.nb_last    = (dy_reg == 2'd2);
    assign stat.out_free   = !rsp_valid_reg || rsp_ready;

endmodule

>>> rtl/ogns_ctrl.sv
`timescale 1ns / 1ps

module ogns_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  ogns_pkg::stat_t stat,
    output ogns_pkg::cmd_t  cmd
);
    import ogns_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_P_RD,
        ST_P_LOAD,
        ST_P_WALK,
        ST_P_WR,
        ST_R_RD,
        ST_R_ACC,
        ST_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid && ready_reg)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (stat.is_read)
                begin
                    state_next = ST_R_RD;
                end
                else if (stat.rect_empty)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_P_RD;
                end
            end
            ST_P_RD:
            begin
                cmd.row_rd = 1'b1;
                state_next = ST_P_LOAD;
            end
            ST_P_LOAD:
            begin
                cmd.row_load = 1'b1;
                state_next   = ST_P_WALK;
            end
            ST_P_WALK:
            begin
                cmd.walk = 1'b1;
                if (stat.cell_last)
                begin
                    state_next = ST_P_WR;
                end
            end
            ST_P_WR:
            begin
                cmd.row_wr = 1'b1;
                state_next = stat.row_last ? ST_FIN : ST_P_RD;
            end
            ST_R_RD:
            begin
                state_next = ST_R_ACC;
            end
            ST_R_ACC:
            begin
                cmd.nb_acc = 1'b1;
                state_next = stat.nb_last ? ST_FIN : ST_R_RD;
            end
            ST_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and request ready.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign req_ready = ready_reg;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import ogns_pkg::*;

    localparam int BOARD_MAX   = MAX_DIM_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 128;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    cfg_idx_t         cfg_index;
    logic [CFG_W-1:0] cfg_data;

    ogns_req_if req_ch ();
    ogns_rsp_if rsp_ch ();

    occupancy_grid_neighbor_score_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the board, the free-cell count and the dimension registers.
    bit               occ_map [0:BOARD_MAX*BOARD_MAX-1];
    int               free_cnt;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    req_t req_pending_q [$];
    rsp_t predicted_rsp_q [$];

    int  req_issued;
    int  req_accepted;
    int  mismatches;
    int  cycle_cnt;
    int  req_gap;
    int  rdy_gap;
    int  hold_ask;
    int  hold_seen;
    int  hold_left;
    bit  quiet;

    // Clock with a 10 ns period.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // A register value of zero acts as one, anything above the limit as the limit.
    function automatic int eff_dim(input logic [CFG_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > BOARD_MAX)
            return BOARD_MAX;
        return int'(v);
    endfunction

    function automatic int clip_coord(input logic signed [COORD_W-1:0] v, input int hi);
        int s;
        s = int'(v);
        if (s < 0)
            return 0;
        if (s > hi)
            return hi;
        return s;
    endfunction

    // Cells outside the board count as occupied.
    function automatic bit is_blocked(input int x, input int y, input int w, input int h);
        if (x < 0 || y < 0 || x >= w || y >= h)
            return 1'b1;
        return occ_map[y*BOARD_MAX + x];
    endfunction

    // Apply one request to the shadow board and return the result it should give.
    function automatic rsp_t predict_cell(input req_t q);
        rsp_t res;
        int   w, h, x0, x1, y0, y1, x, y, dx, dy;
        res = '0;
        w = eff_dim(width_reg);
        h = eff_dim(height_reg);
        if (q.req_type == REQ_PLACE)
        begin
            x0 = clip_coord(q.rect_left, w);
            x1 = clip_coord(q.rect_right, w);
            y0 = clip_coord(q.rect_top, h);
            y1 = clip_coord(q.rect_bottom, h);
            if (x1 > x0 && y1 > y0)
            begin
                for (y = y0; y < y1; y++)
                begin
                    for (x = x0; x < x1; x++)
                    begin
                        if (!occ_map[y*BOARD_MAX + x])
                        begin
                            occ_map[y*BOARD_MAX + x] = 1'b1;
                            if (free_cnt > 0)
                                free_cnt--;
                        end
                    end
                end
            end
        end
        else
        begin
            x = int'(q.col_x);
            y = int'(q.row_y);
            if (is_blocked(x, y, w, h))
            begin
                res.cell_used = 1'b1;
            end
            else
            begin
                for (dy = -1; dy <= 1; dy++)
                    for (dx = -1; dx <= 1; dx++)
                        if (is_blocked(x + dx, y + dy, w, h))
                            res.cell_score = res.cell_score + SCORE_W'(1);
            end
        end
        res.free_cells = free_cnt[CNT_W-1:0];
        return res;
    endfunction

    // Request builders; fields that the request kind ignores get random values.
    function automatic req_t read_req(input int x, input int y);
        req_t q;
        q.req_type    = REQ_READ;
        q.rect_left   = COORD_W'($urandom);
        q.rect_right  = COORD_W'($urandom);
        q.rect_top    = COORD_W'($urandom);
        q.rect_bottom = COORD_W'($urandom);
        q.col_x       = x[POS_W-1:0];
        q.row_y       = y[POS_W-1:0];
        return q;
    endfunction

    function automatic req_t place_req(input int l, input int r, input int t, input int b);
        req_t q;
        q.req_type    = REQ_PLACE;
        q.rect_left   = l[COORD_W-1:0];
        q.rect_right  = r[COORD_W-1:0];
        q.rect_top    = t[COORD_W-1:0];
        q.rect_bottom = b[COORD_W-1:0];
        q.col_x       = POS_W'($urandom);
        q.row_y       = POS_W'($urandom);
        return q;
    endfunction

    // Write one dimension register; the block is idle whenever this is called.
    task automatic write_dim(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == CFG_BOARD_WIDTH)
            width_reg = val;
        else
            height_reg = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold off new requests until every outstanding result has come back.
    task automatic drain_board_requests();
        while (req_pending_q.size() != 0 || req_issued != req_accepted ||
               predicted_rsp_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Mostly small rectangles near the board, reads mostly near them, and some
    // rectangles that clip to nothing across the whole coordinate range.
    task automatic queue_random_requests(input int count);
        int w, h, k, sel, l, r, t, b, sx, sy, x, y, near_x, near_y, tmp;
        w = eff_dim(width_reg);
        h = eff_dim(height_reg);
        near_x = 0;
        near_y = 0;
        for (k = 0; k < count; k++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 10)
            begin
                l = $urandom_range(0, 511) - 256;
                r = $urandom_range(0, 511) - 256;
                t = $urandom_range(0, 511) - 256;
                b = $urandom_range(0, 511) - 256;
                if (r > l)
                begin
                    tmp = l;
                    l = r;
                    r = tmp;
                end
                req_pending_q.push_back(place_req(l, r, t, b));
            end
            else if (sel < 55)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    sx = $urandom_range(1, 8);
                    sy = $urandom_range(1, 8);
                end
                else
                begin
                    sx = $urandom_range(1, 2);
                    sy = $urandom_range(1, 2);
                end
                l = $urandom_range(0, w + 2) - 2;
                t = $urandom_range(0, h + 2) - 2;
                near_x = l;
                near_y = t;
                req_pending_q.push_back(place_req(l, l + sx, t, t + sy));
            end
            else
            begin
                if (sel < 80)
                begin
                    x = near_x + $urandom_range(0, 3) - 1;
                    y = near_y + $urandom_range(0, 3) - 1;
                    x = (x < 0) ? 0 : ((x > BOARD_MAX-1) ? BOARD_MAX-1 : x);
                    y = (y < 0) ? 0 : ((y > BOARD_MAX-1) ? BOARD_MAX-1 : y);
                end
                else if (sel < 95)
                begin
                    x = $urandom_range(0, (w > BOARD_MAX-1) ? BOARD_MAX-1 : w);
                    y = $urandom_range(0, (h > BOARD_MAX-1) ? BOARD_MAX-1 : h);
                end
                else
                begin
                    x = $urandom_range(0, BOARD_MAX-1);
                    y = $urandom_range(0, BOARD_MAX-1);
                end
                req_pending_q.push_back(read_req(x, y));
            end
        end
    endtask

    // Request driver: offers the next pending request once the last one is taken.
    always @(negedge clk)
    begin
        req_t item;
        if (rst_n)
        begin
            if (!req_ch.valid || req_issued == req_accepted)
            begin
                if (req_gap > 0)
                begin
                    req_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (req_pending_q.size() > 0)
                begin
                    item = req_pending_q.pop_front();
                    req_ch.req_type    <= item.req_type;
                    req_ch.rect_left   <= item.rect_left;
                    req_ch.rect_right  <= item.rect_right;
                    req_ch.rect_top    <= item.rect_top;
                    req_ch.rect_bottom <= item.rect_bottom;
                    req_ch.col_x       <= item.col_x;
                    req_ch.row_y       <= item.row_y;
                    req_ch.valid       <= 1'b1;
                    req_issued++;
                    if (!quiet && $urandom_range(0, 7) == 0)
                        req_gap = $urandom_range(1, 3);
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random short stalls, and a long hold when asked.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_seen != hold_ask)
            begin
                hold_seen = hold_ask;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (quiet)
            begin
                rsp_ch.ready <= 1'b1;
            end
            else if (rdy_gap > 0)
            begin
                rdy_gap--;
                rsp_ch.ready <= 1'b0;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                rdy_gap = $urandom_range(0, 2);
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Monitor: predicts on each accepted request and checks each accepted result.
    always @(posedge clk)
    begin
        req_t q;
        rsp_t want;
        if (rst_n)
        begin
            cycle_cnt++;
            if (cycle_cnt > CYCLE_LIMIT)
            begin
                $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
                $display("RESULT: ERROR");
                $finish;
            end
            if (req_ch.valid && req_ch.ready)
            begin
                q.req_type    = req_ch.req_type;
                q.rect_left   = req_ch.rect_left;
                q.rect_right  = req_ch.rect_right;
                q.rect_top    = req_ch.rect_top;
                q.rect_bottom = req_ch.rect_bottom;
                q.col_x       = req_ch.col_x;
                q.row_y       = req_ch.row_y;
                predicted_rsp_q.push_back(predict_cell(q));
                req_accepted++;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (predicted_rsp_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result used=%0d score=%0d free=%0d", $time,
                             rsp_ch.cell_used, rsp_ch.cell_score, rsp_ch.free_cells);
                end
                else
                begin
                    want = predicted_rsp_q.pop_front();
                    if (rsp_ch.cell_used !== want.cell_used)
                    begin
                        mismatches++;
                        $display("%0t: cell_used expected %0d actual %0d", $time,
                                 want.cell_used, rsp_ch.cell_used);
                    end
                    if (rsp_ch.cell_score !== want.cell_score)
                    begin
                        mismatches++;
                        $display("%0t: cell_score expected %0d actual %0d", $time,
                                 want.cell_score, rsp_ch.cell_score);
                    end
                    if (rsp_ch.free_cells !== want.free_cells)
                    begin
                        mismatches++;
                        $display("%0t: free_cells expected %0d actual %0d", $time,
                                 want.free_cells, rsp_ch.free_cells);
                    end
                end
            end
        end
    end

    // Stimulus sequence.
    initial
    begin
        int ph, mark;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_BOARD_WIDTH;
        cfg_data           = '0;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = 1'b0;
        req_ch.rect_left   = '0;
        req_ch.rect_right  = '0;
        req_ch.rect_top    = '0;
        req_ch.rect_bottom = '0;
        req_ch.col_x       = '0;
        req_ch.row_y       = '0;
        rsp_ch.ready       = 1'b0;
        req_issued   = 0;
        req_accepted = 0;
        mismatches   = 0;
        cycle_cnt    = 0;
        req_gap      = 0;
        rdy_gap      = 0;
        hold_ask     = 0;
        hold_seen    = 0;
        hold_left    = 0;
        quiet        = 1'b0;
        width_reg    = DIM_RST;
        height_reg   = DIM_RST;
        for (int i = 0; i < BOARD_MAX*BOARD_MAX; i++)
            occ_map[i] = 1'b0;
        free_cnt = eff_dim(width_reg) * eff_dim(height_reg);

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Fresh board: corners against the border, a free middle cell.
        req_pending_q.push_back(read_req(0, 0));
        req_pending_q.push_back(read_req(63, 63));
        req_pending_q.push_back(read_req(30, 30));
        req_pending_q.push_back(read_req(63, 0));
        // Rectangles that clip to nothing: off the board, zero width, reversed, beyond the far edge.
        req_pending_q.push_back(place_req(-256, -1, -256, -1));
        req_pending_q.push_back(place_req(5, 5, 0, 10));
        req_pending_q.push_back(place_req(0, 10, 7, 3));
        req_pending_q.push_back(place_req(100, 255, 100, 255));
        // A small block and reads on and around it.
        req_pending_q.push_back(place_req(10, 12, 20, 22));
        req_pending_q.push_back(read_req(11, 21));
        req_pending_q.push_back(read_req(9, 19));
        req_pending_q.push_back(read_req(12, 21));
        // Rectangles clipped down to a corner cell and a corner block.
        req_pending_q.push_back(place_req(-256, 1, -256, 1));
        req_pending_q.push_back(read_req(1, 1));
        req_pending_q.push_back(read_req(0, 1));
        req_pending_q.push_back(place_req(62, 255, 62, 255));
        req_pending_q.push_back(read_req(61, 61));
        req_pending_q.push_back(read_req(63, 63));
        drain_board_requests();

        // Out-of-range dimensions: zero acts as one column, 127 as the limit.
        write_dim(CFG_BOARD_WIDTH, 7'd0);
        write_dim(CFG_BOARD_HEIGHT, 7'd127);
        req_pending_q.push_back(read_req(0, 5));
        req_pending_q.push_back(read_req(5, 5));
        req_pending_q.push_back(place_req(-1, 3, 2, 4));
        req_pending_q.push_back(read_req(0, 1));
        req_pending_q.push_back(read_req(0, 63));
        drain_board_requests();

        // Random phases, each under its own board size.
        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:
                begin
                    write_dim(CFG_BOARD_WIDTH, 7'd64);
                    write_dim(CFG_BOARD_HEIGHT, 7'd64);
                end
                1:
                begin
                    write_dim(CFG_BOARD_WIDTH, 7'd40);
                    write_dim(CFG_BOARD_HEIGHT, 7'd64);
                end
                2:
                begin
                    write_dim(CFG_BOARD_WIDTH, 7'd65);
                    write_dim(CFG_BOARD_HEIGHT, 7'd1);
                end
                3:
                begin
                    write_dim(CFG_BOARD_WIDTH, 7'd1);
                    write_dim(CFG_BOARD_HEIGHT, 7'd33);
                end
                4:
                begin
                    write_dim(CFG_BOARD_WIDTH, 7'd20);
                    write_dim(CFG_BOARD_HEIGHT, 7'd17);
                end
                5:
                begin
                    write_dim(CFG_BOARD_WIDTH, CFG_W'($urandom_range(2, 64)));
                    write_dim(CFG_BOARD_HEIGHT, CFG_W'($urandom_range(2, 64)));
                end
                6:
                begin
                    write_dim(CFG_BOARD_WIDTH, 7'd64);
                    write_dim(CFG_BOARD_HEIGHT, 7'd48);
                end
                default:
                begin
                    write_dim(CFG_BOARD_WIDTH, 7'd64);
                    write_dim(CFG_BOARD_HEIGHT, 7'd64);
                    quiet = 1'b1;
                end
            endcase
            mark = req_accepted;
            queue_random_requests(PHASE_ITEMS);
            // Stall the result side long enough for the block to back up.
            if (ph == 0 || ph == 6)
            begin
                while (req_accepted < mark + 5)
                    @(negedge clk);
                hold_ask++;
            end
            drain_board_requests();
        end

        // Fill the whole board so the free count reaches zero.
        req_pending_q.push_back(place_req(-256, 255, -256, 255));
        req_pending_q.push_back(read_req(0, 0));
        req_pending_q.push_back(read_req(32, 17));
        req_pending_q.push_back(place_req(3, 9, 3, 9));
        req_pending_q.push_back(read_req(63, 63));
        drain_board_requests();
        repeat (50) @(negedge clk);

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/ogns_pkg.sv
rtl/ogns_if.sv
rtl/ogns_row_mem.sv
rtl/ogns_dp.sv
rtl/ogns_ctrl.sv
rtl/occupancy_grid_neighbor_score_core.sv
tb/tb_top.sv
